// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks sampled on clk and switched off while rst is high.

`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rtfb_pkg.sv
package rtfb_pkg;

  localparam int unsigned POS_W = 5;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_START      = pos_t'(0);
  localparam pos_t POS_LEN_HI     = pos_t'(1);
  localparam pos_t POS_LEN_LO     = pos_t'(2);
  localparam pos_t POS_TYPE       = pos_t'(3);
  localparam pos_t POS_ID         = pos_t'(4);
  localparam pos_t POS_ADDR_LAST  = pos_t'(12);
  localparam pos_t POS_OPT        = pos_t'(13);
  localparam pos_t POS_TAG        = pos_t'(14);
  localparam pos_t POS_VAL_FIRST  = pos_t'(15);
  localparam pos_t POS_VAL_LAST   = pos_t'(26);
  localparam pos_t POS_CSUM       = pos_t'(27);

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] LEN_HI      = 8'h00;
  localparam logic [7:0] LEN_LO      = 8'h18;
  localparam logic [7:0] FRAME_TYPE  = 8'h00;

  localparam logic [7:0] FRAME_ID_RESET    = 8'h01;
  localparam logic [7:0] TX_OPTIONS_RESET  = 8'h10;
  localparam logic [7:0] PAYLOAD_TAG_RESET = 8'hA0;

  localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_F = 8'd102;

  typedef enum logic [1:0] {
    CFG_FRAME_ID    = 2'd0,
    CFG_TX_OPTIONS  = 2'd1,
    CFG_PAYLOAD_TAG = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] address;
    logic [95:0] values;
    logic        bad;
  } cmd_t;

  // Returns {bad, nibble}; a character that is not lowercase hex decodes to zero.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      diff = c - CHAR_DIGIT_0;
      return {1'b0, diff[3:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      diff = c - CHAR_LOWER_A + 8'd10;
      return {1'b0, diff[3:0]};
    end
    return {1'b1, diff[3:0]};
  endfunction

endpackage

// File: hdl/radio_tx_frame_builder_top.sv
// Transmit-request framer: each command beat (sixteen lowercase hex address characters and three
// 32-bit values) becomes a 28-byte frame sent one byte per output beat, ending with the checksum
// beat that carries last_byte. The serializer emits one byte per cycle while the output is not
// stalled. One decoded command waits in a buffer while the previous frame is sent, and the first
// byte of a frame passes from that buffer through the held command to the output register. A
// command with any address character that is not lowercase hex decodes those nibbles as zero and
// raises bad_address_char on every byte of its frame. Configuration writes take effect on frames
// sent afterwards and should be made only while the block is idle.
`include "assert_macros.svh"

module radio_tx_frame_builder_top
  import rtfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [63:0] address_text_high,
  input  logic [63:0] address_text_low,
  input  logic [31:0] speed_x_bits,
  input  logic [31:0] speed_y_bits,
  input  logic [31:0] turn_rate_bits,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic        bad_address_char
);

  logic [7:0] frame_id;
  logic [7:0] tx_options;
  logic [7:0] payload_tag;

  cmd_t        parsed;
  cmd_t        pend;
  logic        pend_valid;
  cmd_t        held;
  logic        active;
  pos_t        pos;
  logic [7:0]  sum;

  logic        take;
  logic        out_free;
  logic        step;
  logic        last_step;
  logic        load;
  logic [7:0]  cur_byte;
  logic        in_sum;
  pos_t        addr_diff;
  pos_t        val_diff;

  rtfb_hex_parse u_parse (
    .text_high (address_text_high),
    .text_low  (address_text_low),
    .address   (parsed.address),
    .bad       (parsed.bad)
  );

  assign parsed.values = {turn_rate_bits, speed_y_bits, speed_x_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id    <= FRAME_ID_RESET;
      tx_options  <= TX_OPTIONS_RESET;
      payload_tag <= PAYLOAD_TAG_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_ID:    frame_id    <= cfg_data;
        CFG_TX_OPTIONS:  tx_options  <= cfg_data;
        CFG_PAYLOAD_TAG: payload_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_stall = pend_valid;
  assign take      = cmd_valid && !cmd_stall;
  assign out_free  = !byte_valid || !byte_stall;
  assign step      = active && out_free;
  assign last_step = step && (pos == POS_CSUM);
  assign load      = pend_valid && (!active || last_step);

  assign addr_diff = POS_ADDR_LAST - pos;
  assign val_diff  = pos - POS_VAL_FIRST;
  assign in_sum    = (pos >= POS_TYPE) && (pos <= POS_VAL_LAST);

  always_comb begin
    if (pos == POS_START) begin
      cur_byte = START_DELIM;
    end else if (pos == POS_LEN_HI) begin
      cur_byte = LEN_HI;
    end else if (pos == POS_LEN_LO) begin
      cur_byte = LEN_LO;
    end else if (pos == POS_TYPE) begin
      cur_byte = FRAME_TYPE;
    end else if (pos == POS_ID) begin
      cur_byte = frame_id;
    end else if (pos <= POS_ADDR_LAST) begin
      cur_byte = held.address[{addr_diff[2:0], 3'b000} +: 8];
    end else if (pos == POS_OPT) begin
      cur_byte = tx_options;
    end else if (pos == POS_TAG) begin
      cur_byte = payload_tag;
    end else if (pos <= POS_VAL_LAST) begin
      cur_byte = held.values[{val_diff[3:0], 3'b000} +: 8];
    end else begin
      cur_byte = ~sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (take) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= parsed;
    end
    if (load) begin
      held <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= POS_START;
      sum    <= 8'd0;
    end else if (load) begin
      active <= 1'b1;
      pos    <= POS_START;
      sum    <= 8'd0;
    end else if (step) begin
      if (last_step) begin
        active <= 1'b0;
        pos    <= POS_START;
      end else begin
        pos <= pos + pos_t'(1);
      end
      if (in_sum) begin
        sum <= sum + cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (step) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_byte       <= cur_byte;
      last_byte        <= (pos == POS_CSUM);
      bad_address_char <= held.bad;
    end
  end

  `ASSERT_ALWAYS(a_pos_range, !active || pos <= POS_CSUM, "byte position ran past the checksum")
  `ASSERT_NEXT(a_start_frame, pend_valid && !active, active && pos == POS_START, "buffered command did not start a frame")
  `ASSERT_NEXT(a_bad_steady, byte_valid && !byte_stall && !last_byte, bad_address_char == $past(bad_address_char), "bad flag changed inside a frame")

endmodule

// File: hdl/rtfb_hex_parse.sv
module rtfb_hex_parse
  import rtfb_pkg::*;
(
  input  logic [63:0] text_high,
  input  logic [63:0] text_low,
  output logic [63:0] address,
  output logic        bad
);

  logic [127:0] text;
  logic [15:0]  bad_bits;

  assign text = {text_high, text_low};

  for (genvar k = 0; k < 16; k++) begin : g_char
    assign {bad_bits[k], address[63-4*k -: 4]} = hex_nibble(text[127-8*k -: 8]);
  end

  assign bad = |bad_bits;

endmodule

// File: dv/tb_radio_tx_frame_builder_top.sv
module tb_radio_tx_frame_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtfb_pkg::*;

  localparam int FRAME_BYTES = 28;
  localparam int RANDOM_PER_PHASE = 21;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [63:0] address_text_high;
    logic [63:0] address_text_low;
    logic [31:0] speed_x_bits;
    logic [31:0] speed_y_bits;
    logic [31:0] turn_rate_bits;
  } tx_cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       bad_address_char;
  } frame_beat_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_RUNS
  } stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [63:0] address_text_high = '0;
  logic [63:0] address_text_low = '0;
  logic [31:0] speed_x_bits = '0;
  logic [31:0] speed_y_bits = '0;
  logic [31:0] turn_rate_bits = '0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        bad_address_char;

  tx_cmd_t     cmd_backlog[$];
  frame_beat_t beats_due[$];
  tx_cmd_t     on_port;

  logic [7:0] id_reg = FRAME_ID_RESET;
  logic [7:0] opt_reg = TX_OPTIONS_RESET;
  logic [7:0] tag_reg = PAYLOAD_TAG_RESET;

  int mismatches = 0;
  int cmds_sent = 0;
  int beats_checked = 0;
  int flagged_frames = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  frame_beat_t seen_beat;
  frame_beat_t want_beat;

  radio_tx_frame_builder_top u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .address_text_high(address_text_high),
    .address_text_low (address_text_low),
    .speed_x_bits     (speed_x_bits),
    .speed_y_bits     (speed_y_bits),
    .turn_rate_bits   (turn_rate_bits),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .bad_address_char (bad_address_char)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Returns {bad, value} for eight characters; a character that is not lowercase hex counts as zero.
  function automatic logic [32:0] decode_half(input logic [63:0] text);
    logic [31:0] acc;
    logic        bad;
    logic [7:0]  c;
    acc = '0;
    bad = 1'b0;
    for (int k = 0; k < 8; k++) begin
      c = text[63-8*k -: 8];
      acc = acc << 4;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
        acc[3:0] = 4'(c - CHAR_DIGIT_0);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
        acc[3:0] = 4'(c - CHAR_LOWER_A + 8'd10);
      end else begin
        bad = 1'b1;
      end
    end
    return {bad, acc};
  endfunction

  task automatic queue_frame(input tx_cmd_t c);
    logic [32:0] hi_d;
    logic [32:0] lo_d;
    logic [63:0] addr;
    logic [31:0] words [3];
    logic        bad;
    logic [7:0]  sum;
    frame_beat_t beat;
    int          off;
    hi_d = decode_half(c.address_text_high);
    lo_d = decode_half(c.address_text_low);
    addr = {hi_d[31:0], lo_d[31:0]};
    bad = hi_d[32] | lo_d[32];
    words[0] = c.speed_x_bits;
    words[1] = c.speed_y_bits;
    words[2] = c.turn_rate_bits;
    sum = '0;
    for (int p = 0; p < FRAME_BYTES; p++) begin
      if (p == POS_START) begin
        beat.frame_byte = START_DELIM;
      end else if (p == POS_LEN_HI) begin
        beat.frame_byte = LEN_HI;
      end else if (p == POS_LEN_LO) begin
        beat.frame_byte = LEN_LO;
      end else if (p == POS_TYPE) begin
        beat.frame_byte = FRAME_TYPE;
      end else if (p == POS_ID) begin
        beat.frame_byte = id_reg;
      end else if (p <= POS_ADDR_LAST) begin
        beat.frame_byte = addr[8*(int'(POS_ADDR_LAST) - p) +: 8];
      end else if (p == POS_OPT) begin
        beat.frame_byte = opt_reg;
      end else if (p == POS_TAG) begin
        beat.frame_byte = tag_reg;
      end else if (p <= POS_VAL_LAST) begin
        off = p - int'(POS_VAL_FIRST);
        beat.frame_byte = words[off/4][8*(off%4) +: 8];
      end else begin
        beat.frame_byte = 8'hFF - sum;
      end
      if (p >= POS_TYPE && p <= POS_VAL_LAST) begin
        sum = sum + beat.frame_byte;
      end
      beat.last_byte = (p == POS_CSUM);
      beat.bad_address_char = bad;
      beats_due.push_back(beat);
    end
    if (bad) begin
      flagged_frames++;
    end
  endtask

  function automatic logic [63:0] hex_text(input logic [31:0] v);
    logic [63:0] t;
    logic [3:0]  n;
    for (int k = 0; k < 8; k++) begin
      n = v[31-4*k -: 4];
      t[63-8*k -: 8] = (n < 4'd10) ? 8'(CHAR_DIGIT_0 + n) : 8'(CHAR_LOWER_A + n - 8'd10);
    end
    return t;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7F80_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic tx_cmd_t random_cmd();
    tx_cmd_t    c;
    int         pick;
    int         n;
    logic [7:0] junk;
    pick = $urandom_range(0, 99);
    c.address_text_high = hex_text($urandom);
    c.address_text_low = hex_text($urandom);
    if (pick < 6) begin
      c.address_text_high = {$urandom, $urandom};
      c.address_text_low = {$urandom, $urandom};
    end else if (pick < 20) begin
      n = $urandom_range(0, 15);
      junk = 8'($urandom_range(0, 255));
      if (n < 8) begin
        c.address_text_high[63-8*n -: 8] = junk;
      end else begin
        c.address_text_low[63-8*(n-8) -: 8] = junk;
      end
    end
    c.speed_x_bits = random_value();
    c.speed_y_bits = random_value();
    c.turn_rate_bits = random_value();
    return c;
  endfunction

  task automatic add_cmd(input logic [63:0] hi, input logic [63:0] lo,
                         input logic [31:0] x, input logic [31:0] y, input logic [31:0] t);
    tx_cmd_t c;
    c.address_text_high = hi;
    c.address_text_low = lo;
    c.speed_x_bits = x;
    c.speed_y_bits = y;
    c.turn_rate_bits = t;
    cmd_backlog.push_back(c);
  endtask

  task automatic add_random(input int count);
    repeat (count) begin
      cmd_backlog.push_back(random_cmd());
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (cmd_backlog.size() != 0 || cmd_valid || beats_due.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FRAME_ID:    id_reg = val;
      CFG_TX_OPTIONS:  opt_reg = val;
      CFG_PAYLOAD_TAG: tag_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] id, input logic [7:0] opt,
                            input logic [7:0] tag, input logic poke_unused);
    write_reg(CFG_FRAME_ID, id);
    write_reg(CFG_TX_OPTIONS, opt);
    write_reg(CFG_PAYLOAD_TAG, tag);
    if (poke_unused) begin
      write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        queue_frame(on_port);
        cmds_sent++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          on_port = cmd_backlog.pop_front();
          address_text_high <= on_port.address_text_high;
          address_text_low <= on_port.address_text_low;
          speed_x_bits <= on_port.speed_x_bits;
          speed_y_bits <= on_port.speed_y_bits;
          turn_rate_bits <= on_port.turn_rate_bits;
          cmd_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(20, 150);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:   byte_stall <= 1'b0;
        STALL_SPARSE: byte_stall <= ($urandom_range(0, 3) == 0);
        default:      byte_stall <= ((stall_left % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      seen_beat.frame_byte = frame_byte;
      seen_beat.last_byte = last_byte;
      seen_beat.bad_address_char = bad_address_char;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected frame beat: byte %02h last %0b bad %0b",
                   frame_byte, last_byte, bad_address_char);
        end
      end else begin
        want_beat = beats_due.pop_front();
        beats_checked++;
        if (seen_beat !== want_beat) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("beat %0d mismatch: byte %02h/%02h last %0b/%0b bad %0b/%0b (exp/act)",
                     beats_checked, want_beat.frame_byte, seen_beat.frame_byte,
                     want_beat.last_byte, seen_beat.last_byte,
                     want_beat.bad_address_char, seen_beat.bad_address_char);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_radio_tx_frame_builder_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_cmd("00000000", "00000000", 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_cmd("ffffffff", "ffffffff", 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd("01234567", "89abcdef", 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000);
    add_cmd("fedcba98", "76543210", 32'h8000_0000, 32'h7FC0_0000, 32'h0000_0001);
    add_cmd("99999999", "aaaaaaaa", 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
    add_cmd("/0000000", "00000000", 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_cmd("00000000", "1234567:", 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    add_cmd({"abcdef0", 8'h60}, "00000000", 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0000_0000);
    add_cmd("abcdef01", "g0000000", 32'h0000_0080, 32'h8000_0000, 32'hFF00_FF00);
    add_cmd("ABCDEF01", "23456789", 32'h4049_0FDB, 32'hC049_0FDB, 32'h0000_0000);
    add_cmd(64'h0, "0123abcd", 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    add_cmd("aaaabbbb", 64'hFFFF_FFFF_FFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_0000);
    add_cmd("0000000f", "0000000F", 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    add_cmd("9a9a9a9a", "f0f0f0f0", 32'h7F7F_7F7F, 32'h8080_8080, 32'hFEFE_FEFE);
    add_cmd("deadbeef", "cafef00d", $urandom, $urandom, $urandom);
    add_cmd("0a1b2c3d", "4e5f6071", $urandom, $urandom, $urandom);
    add_random(10);
    wait_idle();

    set_config(8'h00, 8'h00, 8'h00, 1'b1);
    add_random(RANDOM_PER_PHASE);
    wait_idle();

    set_config(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_random(RANDOM_PER_PHASE);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b1);
    add_random(RANDOM_PER_PHASE);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 1'b0);
    add_random(RANDOM_PER_PHASE);
    wait_idle();

    set_config(FRAME_ID_RESET, TX_OPTIONS_RESET, PAYLOAD_TAG_RESET, 1'b0);
    add_random(20);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands under %0d register settings; checked %0d frame bytes.",
             cmds_sent, settings_used, beats_checked);
    $display("%0d frames carried the bad address flag; %0d mismatches seen.",
             flagged_frames, mismatches);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("tb_radio_tx_frame_builder_top: done, clean");
    end else begin
      $display("tb_radio_tx_frame_builder_top: done, errors");
    end
    $finish;
  end

endmodule
